>>> hdl/fpd_pkg.sv
// Package for the flight phase detector: field widths, codes, item and configuration types.
// Used by the front end, the back end and the top level; it depends on nothing else.
package fpd_pkg;

	localparam int ACCEL_W = 16;
	localparam int ALT_W = 24;
	localparam int LAUNCH_W = 15;
	localparam int COUNT_W = 16;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 24;
	localparam int LANDING_ACCEL = 2500;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IW-1:0] CFG_LAUNCH_ACCEL = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_LANDING_ALT = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_MIN_SAMPLES = 2'd2;

	typedef enum logic [1:0] {
		MODE_ACCEL = 2'd0,
		MODE_ALT = 2'd1,
		MODE_EVAL = 2'd2,
		MODE_FORCE = 2'd3
	} op_kind_t;

	typedef enum logic [1:0] {
		PH_PAD = 2'd0,
		PH_ASCENT = 2'd1,
		PH_DESCENT = 2'd2,
		PH_LANDED = 2'd3
	} phase_t;

	typedef struct packed {
		logic [1:0] mode;
		logic signed [ACCEL_W-1:0] accel_sample;
		logic signed [ALT_W-1:0] altitude_sample;
		logic [1:0] forced_state;
	} in_item_t;

	typedef struct packed {
		logic state_changed;
		logic [1:0] flight_phase;
	} out_item_t;

	typedef struct packed {
		op_kind_t kind;
		logic signed [ALT_W-1:0] sample;
		phase_t forced;
	} op_t;

	typedef struct packed {
		logic [LAUNCH_W-1:0] launch_accel_threshold;
		logic signed [ALT_W-1:0] landing_altitude_threshold;
		logic [COUNT_W-1:0] min_accel_samples;
	} cfg_t;

endpackage

>>> hdl/fpd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package is needed.
module fpd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/fpd_fifo.sv
// Small register queue with push/full and pop/empty sides.
// Stands alone; no package is needed.
module fpd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hdl/fpd_front.sv
// Front end: takes input items, decodes the mode into an operation and queues it.
// Depends on fpd_pkg and fpd_fifo.
module fpd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  fpd_pkg::in_item_t item,
	output fpd_pkg::op_t      op,
	output logic              op_valid,
	input  logic              op_pop
);

	import fpd_pkg::*;

	localparam int OPW = $bits(op_t);

	op_t op_d;
	logic [OPW-1:0] op_q;
	logic op_empty;

	always_comb begin
		op_d.kind = op_kind_t'(item.mode);
		op_d.forced = phase_t'(item.forced_state);
		unique case (op_kind_t'(item.mode))
			MODE_ACCEL: op_d.sample = {{(ALT_W - ACCEL_W){item.accel_sample[ACCEL_W-1]}},
				item.accel_sample};
			MODE_ALT: op_d.sample = item.altitude_sample;
			MODE_EVAL, MODE_FORCE: op_d.sample = '0;
			default: op_d.sample = '0;
		endcase
	end

	fpd_fifo #(
		.WIDTH(OPW),
		.DEPTH(QUEUE_DEPTH)
	) u_op_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(op_d),
		.full(full),
		.pop(op_pop),
		.rdata(op_q),
		.empty(op_empty)
	);

	assign op = op_t'(op_q);
	assign op_valid = !op_empty;

endmodule

>>> hdl/fpd_back.sv
// Back end: window memories, running sums, the phase checks and the result queue.
// Depends on fpd_pkg, fpd_ram and fpd_fifo.
module fpd_back #(
	parameter int ACCEL_WINDOW = 64,
	parameter int ALT_WINDOW = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fpd_pkg::op_t       op,
	input  logic               op_valid,
	output logic               op_pop,
	input  fpd_pkg::cfg_t      cfg,
	output fpd_pkg::out_item_t result,
	output logic               empty,
	input  logic               pop
);

	import fpd_pkg::*;

	localparam int AIW = $clog2(ACCEL_WINDOW);
	localparam int LIW = $clog2(ALT_WINDOW);
	localparam int ACC_SW = ACCEL_W + AIW;
	localparam int ALT_SW = ALT_W + LIW;
	localparam int RESW = $bits(out_item_t);
	localparam logic signed [ACC_SW-1:0] LAND_ACC = ACC_SW'(LANDING_ACCEL * ACCEL_WINDOW);
	localparam logic [ACC_SW-1:0] ACC_W_U = ACC_SW'(ACCEL_WINDOW);
	localparam logic signed [ALT_SW-1:0] ALT_W_S = ALT_SW'(ALT_WINDOW);

	logic [AIW-1:0] a_rd_idx_q, a_idx_s1;
	logic [LIW-1:0] l_rd_idx_q, l_idx_s1;
	logic [ACCEL_WINDOW-1:0] a_vld_q;
	logic [ALT_WINDOW-1:0] l_vld_q;
	logic a_vld_s1, l_vld_s1;
	logic valid_s1;
	op_t op_s1;
	logic [ACCEL_W-1:0] a_rdata, a_old;
	logic [ALT_W-1:0] l_rdata, l_old;
	logic signed [ACC_SW-1:0] a_sum_q, a_sum_d;
	logic signed [ALT_SW-1:0] l_sum_q, l_sum_d;
	logic [COUNT_W-1:0] count_q, count_d;
	phase_t phase_q, phase_d;
	logic armed_q, armed_d, changed;
	logic [ACC_SW-1:0] acc_abs, acc_lim;
	logic signed [ALT_SW-1:0] alt_thr_x, alt_lim;
	logic res_full, s1_free, advance, acc_pop, alt_pop, acc_wr, alt_wr;
	out_item_t res_d;
	logic [RESW-1:0] res_q;

	assign s1_free = !valid_s1 || !res_full;
	assign advance = valid_s1 && !res_full;
	assign op_pop = op_valid && s1_free;
	assign acc_pop = op_pop && (op.kind == MODE_ACCEL);
	assign alt_pop = op_pop && (op.kind == MODE_ALT);
	assign acc_wr = advance && (op_s1.kind == MODE_ACCEL);
	assign alt_wr = advance && (op_s1.kind == MODE_ALT);

	fpd_ram #(
		.WIDTH(ACCEL_W),
		.DEPTH(ACCEL_WINDOW)
	) u_accel_ram (
		.clk(clk),
		.we(acc_wr),
		.waddr(a_idx_s1),
		.wdata(op_s1.sample[ACCEL_W-1:0]),
		.re(acc_pop),
		.raddr(a_rd_idx_q),
		.rdata(a_rdata)
	);

	fpd_ram #(
		.WIDTH(ALT_W),
		.DEPTH(ALT_WINDOW)
	) u_alt_ram (
		.clk(clk),
		.we(alt_wr),
		.waddr(l_idx_s1),
		.wdata(op_s1.sample),
		.re(alt_pop),
		.raddr(l_rd_idx_q),
		.rdata(l_rdata)
	);

	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_s1 <= op;
			a_idx_s1 <= a_rd_idx_q;
			l_idx_s1 <= l_rd_idx_q;
			a_vld_s1 <= a_vld_q[a_rd_idx_q];
			l_vld_s1 <= l_vld_q[l_rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			a_rd_idx_q <= '0;
			l_rd_idx_q <= '0;
			a_vld_q <= '0;
			l_vld_q <= '0;
			a_sum_q <= '0;
			l_sum_q <= '0;
			count_q <= '0;
			phase_q <= PH_PAD;
			armed_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= op_valid;
			end
			if (acc_pop) begin
				a_rd_idx_q <= (a_rd_idx_q == AIW'(ACCEL_WINDOW - 1)) ? '0 : a_rd_idx_q + 1'b1;
			end
			if (alt_pop) begin
				l_rd_idx_q <= (l_rd_idx_q == LIW'(ALT_WINDOW - 1)) ? '0 : l_rd_idx_q + 1'b1;
			end
			if (acc_wr) begin
				a_vld_q[a_idx_s1] <= 1'b1;
			end
			if (alt_wr) begin
				l_vld_q[l_idx_s1] <= 1'b1;
			end
			if (advance) begin
				a_sum_q <= a_sum_d;
				l_sum_q <= l_sum_d;
				count_q <= count_d;
				phase_q <= phase_d;
				armed_q <= armed_d;
			end
		end
	end

	assign a_old = a_vld_s1 ? a_rdata : '0;
	assign l_old = l_vld_s1 ? l_rdata : '0;
	assign acc_abs = a_sum_q[ACC_SW-1] ? ACC_SW'(-a_sum_q) : ACC_SW'(a_sum_q);
	assign acc_lim = ACC_SW'(cfg.launch_accel_threshold) * ACC_W_U;
	assign alt_thr_x = {{LIW{cfg.landing_altitude_threshold[ALT_W-1]}},
		cfg.landing_altitude_threshold};
	assign alt_lim = alt_thr_x * ALT_W_S;

	always_comb begin
		a_sum_d = a_sum_q;
		l_sum_d = l_sum_q;
		count_d = count_q;
		phase_d = phase_q;
		armed_d = armed_q;
		changed = 1'b0;
		unique case (op_s1.kind)
			MODE_ACCEL: begin
				a_sum_d = a_sum_q
					+ {{AIW{op_s1.sample[ACCEL_W-1]}}, op_s1.sample[ACCEL_W-1:0]}
					- {{AIW{a_old[ACCEL_W-1]}}, a_old};
				count_d = (count_q == '1) ? count_q : count_q + 1'b1;
			end
			MODE_ALT: begin
				l_sum_d = l_sum_q + {{LIW{op_s1.sample[ALT_W-1]}}, op_s1.sample}
					- {{LIW{l_old[ALT_W-1]}}, l_old};
			end
			MODE_EVAL: begin
				if ((phase_d == PH_PAD && acc_abs > acc_lim
					&& count_q >= cfg.min_accel_samples && l_sum_q > alt_lim)
					|| (phase_d == PH_ASCENT && armed_d)) begin
					phase_d = PH_ASCENT;
					changed = 1'b1;
					armed_d = 1'b0;
				end
				if (((phase_d == PH_ASCENT || phase_d == PH_DESCENT) && l_sum_q < alt_lim
					&& a_sum_q != LAND_ACC) || (phase_d == PH_LANDED && armed_d)) begin
					phase_d = PH_LANDED;
					changed = 1'b1;
					armed_d = 1'b0;
				end
				if ((phase_d == PH_ASCENT && acc_abs < acc_lim)
					|| (phase_d == PH_DESCENT && armed_d)) begin
					phase_d = PH_DESCENT;
					changed = 1'b1;
					armed_d = 1'b0;
				end
			end
			MODE_FORCE: begin
				phase_d = op_s1.forced;
				armed_d = 1'b1;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
		res_d.state_changed = changed;
		res_d.flight_phase = phase_d;
	end

	fpd_fifo #(
		.WIDTH(RESW),
		.DEPTH(QUEUE_DEPTH)
	) u_result_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(advance),
		.wdata(res_d),
		.full(res_full),
		.pop(pop),
		.rdata(res_q),
		.empty(empty)
	);

	assign result = out_item_t'(res_q);

endmodule

>>> hdl/flight_phase_detector_unit.sv
// Top level of the flight phase detector: configuration registers, front end and back end.
// Depends on fpd_pkg, fpd_front and fpd_back.
//
// Items enter through push/full and each gives exactly one result, taken through
// empty/pop in the order the items were accepted. An accepted item is registered in
// the operation queue, then in the back end stage, and then its result is written to
// the result queue, from which it is shown on the result ports.
// One item per cycle is sustained while results are popped; the back end needs no
// extra read for an item, as the window entry it replaces is read from RAM on entry.
// Both queues are two entries deep. When the receiver stops popping, the result
// queue fills, the back end holds its item, the operation queue fills and full rises.
// Configuration is written through cfg_write, cfg_index and cfg_data and takes effect
// for items processed after the write; indexes beyond the list are ignored.
// Reset clears the phase, sums, sample count, indexes and registers at once; the
// window RAMs keep one valid flag per entry, so an entry never written reads as zero
// and no clearing pass is needed.
module flight_phase_detector_unit #(
	parameter int ACCEL_WINDOW = 64,
	parameter int ALT_WINDOW = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  fpd_pkg::in_item_t             item,
	output logic                          empty,
	input  logic                          pop,
	output fpd_pkg::out_item_t            result,
	input  logic                          cfg_write,
	input  logic [fpd_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [fpd_pkg::CFG_DW-1:0]    cfg_data
);

	import fpd_pkg::*;

	cfg_t cfg_q;
	op_t op;
	logic op_valid, op_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LAUNCH_ACCEL: cfg_q.launch_accel_threshold <= cfg_data[LAUNCH_W-1:0];
				CFG_LANDING_ALT: cfg_q.landing_altitude_threshold <= cfg_data[ALT_W-1:0];
				CFG_MIN_SAMPLES: cfg_q.min_accel_samples <= cfg_data[COUNT_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	fpd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.op(op),
		.op_valid(op_valid),
		.op_pop(op_pop)
	);

	fpd_back #(
		.ACCEL_WINDOW(ACCEL_WINDOW),
		.ALT_WINDOW(ALT_WINDOW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.op_valid(op_valid),
		.op_pop(op_pop),
		.cfg(cfg_q),
		.result(result),
		.empty(empty),
		.pop(pop)
	);

	a_full_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> op_valid)
		else $error("Operation queue reports full while it holds nothing.");

	a_accept_reaches_back: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !op_valid) |=> op_valid)
		else $error("Accepted request did not reach the back end.");

	a_issue_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> ##2 !empty)
		else $error("Request taken by the back end produced no result.");

endmodule
